[hw/rtl/pps_pkg.sv]
// Package with the shared types and constants of the priority process scheduler.
package pps_pkg;

	localparam int MaxProcs = 32;
	localparam int IdW      = 6;
	localparam int CntW     = 6;
	localparam int PosW     = 5;

	typedef enum logic [2:0] {
		REQ_CREATE    = 3'd0,
		REQ_NEW_RDY   = 3'd1,
		REQ_WAIT_RDY  = 3'd2,
		REQ_RUN_WAIT  = 3'd3,
		REQ_SCHEDULE  = 3'd4,
		REQ_LIST      = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NO_ID  = 2'd1,
		ST_NOT_IN = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	localparam logic [1:0] SEL_NEW  = 2'd0;
	localparam logic [1:0] SEL_RDY  = 2'd1;
	localparam logic [1:0] SEL_WAIT = 2'd2;

	// Operations applied to a queue of cells.
	typedef enum logic [2:0] {
		QOP_NONE   = 3'd0,
		QOP_APPEND = 3'd1,
		QOP_REMOVE = 3'd2,
		QOP_INSERT = 3'd3,
		QOP_POP    = 3'd4
	} qop_t;

	typedef struct packed {
		qop_t           op;
		logic [IdW-1:0] id;
		logic [1:0]     prio;
	} qcmd_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_EXEC   = 3'd1,
		S_SCHED  = 3'd2,
		S_REINS  = 3'd3,
		S_LIST   = 3'd4,
		S_OUT    = 3'd5
	} state_t;

endpackage

[hw/rtl/pps_cell.sv]
// One queue cell: holds an id and its priority and shifts with its neighbors.
module pps_cell import pps_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  qcmd_t          cmd,
	input  logic           prev_valid,
	input  logic [IdW-1:0] prev_id,
	input  logic [1:0]     prev_prio,
	input  logic           prev_ins_here,
	input  logic           prev_hit,
	input  logic           next_valid,
	input  logic [IdW-1:0] next_id,
	input  logic [1:0]     next_prio,
	input  logic           is_head,
	output logic           valid,
	output logic [IdW-1:0] id,
	output logic [1:0]     prio,
	output logic           ins_here,
	output logic           hit
);

	logic           valid_q;
	logic [IdW-1:0] id_q;
	logic [1:0]     prio_q;
	logic           append_here;

	assign valid = valid_q;
	assign id    = id_q;
	assign prio  = prio_q;
	// Insert point: first valid cell of strictly lower priority, or first empty.
	assign ins_here = prev_ins_here | (valid_q ? (cmd.prio > prio_q) : 1'b1);
	// Remove hit propagates so all cells at and behind the match shift forward.
	assign hit = prev_hit | (valid_q && id_q == cmd.id);
	assign append_here = !valid_q && (is_head || prev_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				QOP_APPEND: if (append_here) valid_q <= 1'b1;
				QOP_INSERT: if (ins_here) valid_q <= prev_ins_here ? prev_valid : 1'b1;
				QOP_REMOVE: if (hit) valid_q <= next_valid;
				QOP_POP:    valid_q <= next_valid;
				default:    valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			QOP_APPEND: if (append_here) begin
				id_q <= cmd.id; prio_q <= cmd.prio;
			end
			QOP_INSERT: if (ins_here) begin
				if (prev_ins_here) begin
					id_q <= prev_id; prio_q <= prev_prio;
				end else begin
					id_q <= cmd.id; prio_q <= cmd.prio;
				end
			end
			QOP_REMOVE: if (hit) begin
				id_q <= next_id; prio_q <= next_prio;
			end
			QOP_POP: begin
				id_q <= next_id; prio_q <= next_prio;
			end
			default: ;
		endcase
	end

endmodule

[hw/rtl/pps_queue.sv]
// A queue built as a chain of cells with a fill count.
module pps_queue import pps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  qcmd_t               cmd,
	output logic [CntW-1:0]     count,
	output logic                found,
	output logic [IdW-1:0]      head_id,
	output logic [MaxProcs-1:0][IdW-1:0] ids
);

	logic [MaxProcs-1:0]          v, ih, ht;
	logic [MaxProcs-1:0][IdW-1:0] idv;
	logic [MaxProcs-1:0][1:0]     pr;
	logic [CntW-1:0]              count_q;

	for (genvar i = 0; i < MaxProcs; i++) begin : g_cell
		pps_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd),
			.prev_valid   (i == 0 ? 1'b0 : v[(i == 0) ? 0 : i-1]),
			.prev_id      (i == 0 ? '0 : idv[(i == 0) ? 0 : i-1]),
			.prev_prio    (i == 0 ? 2'd0 : pr[(i == 0) ? 0 : i-1]),
			.prev_ins_here(i == 0 ? 1'b0 : ih[(i == 0) ? 0 : i-1]),
			.prev_hit     (i == 0 ? 1'b0 : ht[(i == 0) ? 0 : i-1]),
			.next_valid   (i == MaxProcs-1 ? 1'b0 : v[(i == MaxProcs-1) ? i : i+1]),
			.next_id      (i == MaxProcs-1 ? '0 : idv[(i == MaxProcs-1) ? i : i+1]),
			.next_prio    (i == MaxProcs-1 ? 2'd0 : pr[(i == MaxProcs-1) ? i : i+1]),
			.is_head(i == 0),
			.valid(v[i]), .id(idv[i]), .prio(pr[i]), .ins_here(ih[i]), .hit(ht[i])
		);
	end

	assign count   = count_q;
	assign found   = ht[MaxProcs-1];
	assign head_id = idv[0];
	assign ids     = idv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				QOP_APPEND, QOP_INSERT:
					if (count_q != CntW'(MaxProcs)) count_q <= count_q + 1'b1;
				QOP_REMOVE: if (found) count_q <= count_q - 1'b1;
				QOP_POP:    if (count_q != '0) count_q <= count_q - 1'b1;
				default:    count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/priority_process_scheduler_unit.sv]
// Top level of the priority process scheduler: control sequencer and three cell queues.
// Steps: create and moves pass EXEC and OUT; schedule passes EXEC, SCHED and OUT,
// with REINS before OUT when the preempted id is put back; running to waiting passes
// EXEC, SCHED and OUT. One request is taken at a time; a list emits its ids in order.
// The queues are chains of cells that shift by one place per queue command.
// Reset (arst_n low) empties all queues, clears used ids and the running slot.
module priority_process_scheduler_unit import pps_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [2:0]     req_type,
	input  logic [5:0]     proc_id,
	input  logic [1:0]     prio_level,
	input  logic [1:0]     queue_select,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [5:0]     result_pid,
	output logic [1:0]     status,
	output logic           last_item
);

	state_t state_q, state_d;

	// Captured request.
	logic [2:0]     req_q;
	logic [IdW-1:0] pid_q;
	logic [1:0]     prio_q;
	logic [1:0]     sel_q;

	// Machine state outside the queues.
	logic [MaxProcs-1:0]      used_q;
	logic [MaxProcs-1:0][1:0] pprio_q;
	logic [IdW-1:0]           run_q;
	logic [IdW-1:0]           preempt_q;

	// Output register.
	logic           ov_q;
	logic [IdW-1:0] opid_q;
	logic [1:0]     ost_q;
	logic           olast_q;

	// List walk.
	logic [PosW-1:0] lidx_q;
	logic [CntW-1:0] lcnt_q;
	logic [MaxProcs-1:0][IdW-1:0] lids_q;

	qcmd_t cmd_new, cmd_rdy, cmd_wait;
	logic [CntW-1:0] cnt_new, cnt_rdy, cnt_wait;
	logic found_new, found_rdy, found_wait;
	logic [IdW-1:0] head_new, head_rdy, head_wait;
	logic [MaxProcs-1:0][IdW-1:0] ids_new, ids_rdy, ids_wait;

	pps_queue u_new (.clk(clk), .arst_n(arst_n), .cmd(cmd_new), .count(cnt_new),
		.found(found_new), .head_id(head_new), .ids(ids_new));
	pps_queue u_rdy (.clk(clk), .arst_n(arst_n), .cmd(cmd_rdy), .count(cnt_rdy),
		.found(found_rdy), .head_id(head_rdy), .ids(ids_rdy));
	pps_queue u_wait (.clk(clk), .arst_n(arst_n), .cmd(cmd_wait), .count(cnt_wait),
		.found(found_wait), .head_id(head_wait), .ids(ids_wait));

	// Lowest never-used id, found by a priority encode over the used bits.
	logic [IdW-1:0] free_id;
	logic           free_ok;
	always_comb begin
		free_id = '0;
		free_ok = 1'b0;
		for (int i = MaxProcs-1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_id = IdW'(i + 1);
				free_ok = 1'b1;
			end
		end
	end

	logic pid_range;
	logic [PosW-1:0] pid_idx;
	assign pid_range = (pid_q != '0) && (pid_q <= IdW'(MaxProcs));
	assign pid_idx   = PosW'(pid_q - 1'b1);

	logic [PosW-1:0] run_idx, pre_idx;
	assign run_idx = PosW'(run_q - 1'b1);
	assign pre_idx = PosW'(preempt_q - 1'b1);

	// Whether the id being moved is found in its source queue; its stored priority goes with it.
	logic move_hit;
	assign move_hit = pid_range &&
		((req_q == REQ_NEW_RDY) ? found_new : found_wait);

	logic [1:0] list_sel_eff;
	logic [CntW-1:0] list_n;
	always_comb begin
		case (sel_q)
			SEL_NEW:  list_n = cnt_new;
			SEL_RDY:  list_n = cnt_rdy;
			SEL_WAIT: list_n = cnt_wait;
			default:  list_n = '0;
		endcase
		list_sel_eff = sel_q;
	end

	// Sequencer and queue commands.
	always_comb begin
		state_d  = state_q;
		cmd_new  = '{op: QOP_NONE, id: pid_q, prio: 2'd0};
		cmd_rdy  = '{op: QOP_NONE, id: pid_q, prio: 2'd0};
		cmd_wait = '{op: QOP_NONE, id: pid_q, prio: 2'd0};
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (req_q)
					REQ_CREATE: begin
						if (free_ok) begin
							cmd_new.op = QOP_APPEND;
							cmd_new.id = free_id;
						end
						state_d = S_OUT;
					end
					REQ_NEW_RDY, REQ_WAIT_RDY: begin
						if (pid_range) begin
							if (req_q == REQ_NEW_RDY) cmd_new.op = QOP_REMOVE;
							else                      cmd_wait.op = QOP_REMOVE;
						end
						if (move_hit) begin
							cmd_rdy.op   = QOP_INSERT;
							cmd_rdy.prio = pprio_q[pid_idx];
						end
						state_d = S_OUT;
					end
					REQ_RUN_WAIT: begin
						if (run_q != '0) begin
							cmd_wait.op = QOP_APPEND;
							cmd_wait.id = run_q;
						end
						state_d = S_SCHED;
					end
					REQ_SCHEDULE: state_d = S_SCHED;
					REQ_LIST: state_d = S_LIST;
					default: state_d = S_IDLE;
				endcase
			end
			S_SCHED: begin
				if (cnt_rdy != '0) cmd_rdy.op = QOP_POP;
				state_d = (cnt_rdy != '0 && run_q != '0) ? S_REINS : S_OUT;
			end
			S_REINS: begin
				cmd_rdy.op   = QOP_INSERT;
				cmd_rdy.id   = preempt_q;
				cmd_rdy.prio = pprio_q[pre_idx];
				state_d      = S_OUT;
			end
			S_LIST: begin
				if (!ov_q || out_ready) begin
					if (lcnt_q == '0 || CntW'(lidx_q) + 1'b1 >= lcnt_q) state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!ov_q || out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q  <= req_type;
			pid_q  <= proc_id;
			prio_q <= (prio_level == 2'd3) ? 2'd2 : prio_level;
			sel_q  <= queue_select;
		end
	end

	// Result fields staged for S_OUT or the list walk.
	logic [IdW-1:0] rpid_q;
	logic [1:0]     rst_q;

	// The output register is loaded when a list entry that is not the last one
	// goes out, or when the final result of a request goes out.
	logic ov_set;
	always_comb begin
		ov_set = 1'b0;
		if (!ov_q || out_ready) begin
			case (state_q)
				S_LIST:  ov_set = (lcnt_q != '0 && CntW'(lidx_q) + 1'b1 < lcnt_q);
				S_OUT:   ov_set = 1'b1;
				default: ov_set = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			run_q  <= '0;
			ov_q   <= 1'b0;
			lidx_q <= '0;
		end else begin
			if (ov_set)         ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (state_q)
				S_EXEC: begin
					lidx_q <= '0;
					case (req_q)
						REQ_CREATE: if (free_ok) used_q[PosW'(free_id - 1'b1)] <= 1'b1;
						REQ_RUN_WAIT: run_q <= '0;
						default: ;
					endcase
				end
				S_SCHED: if (cnt_rdy != '0) run_q <= head_rdy;
				S_LIST: if (ov_set) lidx_q <= lidx_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_EXEC: begin
				case (req_q)
					REQ_CREATE: begin
						if (free_ok) begin
							pprio_q[PosW'(free_id - 1'b1)] <= prio_q;
							rpid_q <= free_id;
							rst_q  <= ST_OK;
						end else begin
							rpid_q <= '0;
							rst_q  <= ST_NO_ID;
						end
					end
					REQ_NEW_RDY, REQ_WAIT_RDY: begin
						rpid_q <= '0;
						rst_q  <= move_hit ? ST_OK : ST_NOT_IN;
					end
					REQ_LIST: begin
						lcnt_q <= list_n;
						case (list_sel_eff)
							SEL_RDY:  lids_q <= ids_rdy;
							SEL_WAIT: lids_q <= ids_wait;
							default:  lids_q <= ids_new;
						endcase
					end
					default: ;
				endcase
			end
			S_SCHED: begin
				preempt_q <= run_q;
				if (cnt_rdy != '0) begin
					rpid_q <= head_rdy;
					rst_q  <= ST_OK;
				end else begin
					rpid_q <= '0;
					rst_q  <= ST_EMPTY;
				end
			end
			S_LIST: if (!ov_q || out_ready) begin
				if (lcnt_q == '0) begin
					rpid_q <= '0;
					rst_q  <= ST_EMPTY;
				end else if (CntW'(lidx_q) + 1'b1 >= lcnt_q) begin
					rpid_q <= lids_q[lidx_q];
					rst_q  <= ST_OK;
				end else begin
					opid_q  <= lids_q[lidx_q];
					ost_q   <= ST_OK;
					olast_q <= 1'b0;
				end
			end
			S_OUT: if (!ov_q || out_ready) begin
				opid_q  <= rpid_q;
				ost_q   <= rst_q;
				olast_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign out_valid  = ov_q;
	assign result_pid = opid_q;
	assign status     = ost_q;
	assign last_item  = olast_q;

	// A result that waits keeps its valid and its payload until the transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(result_pid)
		&& $stable(status) && $stable(last_item))
		else $error("result changed while waiting");
	// The running id always lies in range.
	assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= IdW'(MaxProcs))
		else $error("running id out of range");
	// Queue fill counts never exceed the number of ids.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_new <= CntW'(MaxProcs)) && (cnt_rdy <= CntW'(MaxProcs))
		&& (cnt_wait <= CntW'(MaxProcs)))
		else $error("queue count overflow");

endmodule
